// ===== src/pulse_channel_sample_render_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the pulse channel sample renderer
// Shared concurrent-assertion shorthands, clocked on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef PULSE_CHANNEL_SAMPLE_RENDER_TOP_MACROS_SVH
`define PULSE_CHANNEL_SAMPLE_RENDER_TOP_MACROS_SVH

// Same-cycle implication.
`define PCSR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcsr assertion failed");

// Next-cycle implication.
`define PCSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcsr assertion failed");

`endif

// ===== src/pcsr_pkg.sv =====
// ---------------------------------------------------------------------------
// pcsr_pkg
// Types, codes and tables shared by the pulse channel renderer.
// ---------------------------------------------------------------------------
package pcsr_pkg;

    localparam int PHASE_FRAC_BITS_DEF = 16;
    localparam int QUO_W               = 12;

    localparam logic [2:0] KIND_REG0 = 3'd0;
    localparam logic [2:0] KIND_REG1 = 3'd1;
    localparam logic [2:0] KIND_REG2 = 3'd2;
    localparam logic [2:0] KIND_REG3 = 3'd3;
    localparam logic [2:0] KIND_TICK = 3'd4;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_SELECT = 2'd1;
    localparam logic [1:0] CFG_STEP   = 2'd2;
    localparam logic [1:0] CFG_FRAME  = 2'd3;

    localparam logic [22:0] CYCLE_STEP_RST    = 23'd2659740;
    localparam logic [11:0] FRAME_SAMPLES_RST = 12'd735;
    localparam logic [15:0] SWEEP_DELAY_RST   = 16'd735;
    localparam logic [11:0] PERIOD_LIMIT_RST  = 12'h3FF;
    localparam logic [3:0]  DUTY_THR_RST      = 4'd2;

    localparam logic [7:0] LEN_TABLE [32] = '{
        8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
        8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
        8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
        8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E
    };
    localparam logic [3:0] DUTY_TABLE [4] = '{4'd2, 4'd4, 4'd8, 4'd12};
    localparam logic [11:0] LIMIT_TABLE [8] = '{
        12'h3FF, 12'h555, 12'h666, 12'h71C, 12'h787, 12'h7C1, 12'h7E0, 12'h7F0
    };

    typedef struct packed {
        logic wr;
        logic tick_start;
        logic env_step;
        logic sweep_start;
        logic sweep_step;
        logic phase_sub;
        logic acc_step;
        logic div_init;
        logic div_step;
        logic res_zero;
        logic res_div;
        logic out_load;
    } pcsr_cmd_t;

    typedef struct packed {
        logic gated;
        logic env_neg;
        logic muted;
        logic sweep_active;
        logic sweep_neg;
        logic acc_neg;
        logic out_free;
    } pcsr_sts_t;

endpackage

// ===== src/pulse_channel_sample_render_top.sv =====
// ---------------------------------------------------------------------------
// pulse_channel_sample_render_top
// Pulse channel of a console sound unit rendered at the audio sample rate.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): each word is either a channel register write
//   (s_tuser kind 0..3, s_tdata the register byte) or a sample tick
//   (kind 4). Kinds 5..7 are taken and dropped.
//   Output stream (m_*): one signed 13-bit sample per tick word, none for
//   writes. Config port (cfg_*): enable, sweep negate mode, cycle step and
//   frame length; write only while the channel is idle.
//   Sequence: a register write is taken while the sequencer is idle. A
//   tick that crosses duty steps walks the envelope steps (up to 4),
//   the sweep steps (up to 2) when the sweep runs, the phase step, the
//   one-per-cycle crossing loop (up to 128 crossings at the largest
//   cycle step) and the one-bit-per-cycle 12-bit divider before its
//   sample loads. A gated tick goes straight to output; a muted one
//   stops after the envelope, one without a crossing after the phase step.
//   Throughput: one tick in flight at a time; s_tready is high only when
//   the sequencer is idle, from the cycle after the sample loads.
//   Reset: all channel state returns to its power-up values; no output.
//   Stall: a finished sample waits in the output register; writes keep
//   being taken, and the next tick holds in its last cycle until the
//   register frees.
// ---------------------------------------------------------------------------
`include "pulse_channel_sample_render_top_macros.svh"

module pulse_channel_sample_render_top
#(
    parameter int PHASE_FRAC_BITS = pcsr_pkg::PHASE_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [22:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] write_data
    input  logic [2:0]  s_tuser,   // [2:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [12:0] sample, [15:13] zero
);

    pcsr_pkg::pcsr_cmd_t cmd;
    pcsr_pkg::pcsr_sts_t sts;
    logic [12:0]         sample;

    // Sequencer: walks gate, envelope, sweep, crossing and divide steps.
    pcsr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: channel state plus the output register.
    pcsr_dp #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .in_kind    (s_tuser),
        .in_data    (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_sample (sample)
    );

    assign m_tdata = {3'b000, sample};

    // A tick word always leaves the sequencer busy on the next cycle.
    `PCSR_ASSERT_NEXT(a_tick_busy, s_tvalid && s_tready && (s_tuser == pcsr_pkg::KIND_TICK), !s_tready)
    // Samples stay inside the envelope amplitude range.
    `PCSR_ASSERT_SAME(a_sample_range, m_tvalid, ($signed(sample) <= 13'sd3840) && ($signed(sample) >= -13'sd3840))
    // A new sample is only loaded while the sequencer is not taking words.
    `PCSR_ASSERT_SAME(a_load_busy, cmd.out_load, !s_tready)

endmodule

// ===== src/pcsr_ctrl.sv =====
// ---------------------------------------------------------------------------
// pcsr_ctrl
// Sequencer for register writes and the multi-cycle sample tick.
// ---------------------------------------------------------------------------
module pcsr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2:0]          in_kind,
    output logic                in_ready,
    input  pcsr_pkg::pcsr_sts_t sts,
    output pcsr_pkg::pcsr_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_ENV, S_SWEEP, S_PHASE, S_ACCUM, S_DIV, S_FIN, S_OUT
    } state_t;

    localparam int DC_W = $clog2(pcsr_pkg::QUO_W);

    state_t            state_reg, state_next;
    logic [DC_W-1:0]   div_cnt_reg, div_cnt_next;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        in_ready     = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_kind)
                        pcsr_pkg::KIND_REG0, pcsr_pkg::KIND_REG1,
                        pcsr_pkg::KIND_REG2, pcsr_pkg::KIND_REG3:
                        begin
                            cmd.wr = 1'b1;
                        end
                        pcsr_pkg::KIND_TICK:
                        begin
                            if (sts.gated)
                            begin
                                cmd.res_zero = 1'b1;
                                state_next   = S_OUT;
                            end
                            else
                            begin
                                cmd.tick_start = 1'b1;
                                state_next     = S_ENV;
                            end
                        end
                        default:
                        begin
                            cmd.wr = 1'b0;
                        end
                    endcase
                end
            end
            S_ENV:
            begin
                if (sts.env_neg)
                begin
                    cmd.env_step = 1'b1;
                end
                else if (sts.muted)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = S_OUT;
                end
                else if (sts.sweep_active)
                begin
                    cmd.sweep_start = 1'b1;
                    state_next      = S_SWEEP;
                end
                else
                begin
                    cmd.phase_sub = 1'b1;
                    state_next    = S_PHASE;
                end
            end
            S_SWEEP:
            begin
                if (sts.sweep_neg)
                begin
                    cmd.sweep_step = 1'b1;
                end
                else
                begin
                    cmd.phase_sub = 1'b1;
                    state_next    = S_PHASE;
                end
            end
            S_PHASE:
            begin
                if (sts.acc_neg)
                begin
                    state_next = S_ACCUM;
                end
                else
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_ACCUM:
            begin
                if (sts.acc_neg)
                begin
                    cmd.acc_step = 1'b1;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DC_W'(pcsr_pkg::QUO_W - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                cmd.res_div = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

// ===== src/pcsr_dp.sv =====
// ---------------------------------------------------------------------------
// pcsr_dp
// Channel state, phase accumulator, crossing average and output register.
// ---------------------------------------------------------------------------
module pcsr_dp
#(
    parameter int PHASE_FRAC_BITS = pcsr_pkg::PHASE_FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [22:0]         cfg_data,
    input  logic [2:0]          in_kind,
    input  logic [7:0]          in_data,
    input  pcsr_pkg::pcsr_cmd_t cmd,
    output pcsr_pkg::pcsr_sts_t sts,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [12:0]         out_sample
);

    localparam int PA_W  = PHASE_FRAC_BITS + 18;
    localparam int CNT_W = (PHASE_FRAC_BITS > 20) ? 4 : 24 - PHASE_FRAC_BITS;
    localparam int QW    = pcsr_pkg::QUO_W;
    localparam int REM_W = CNT_W + QW;
    localparam int TOT_W = REM_W + 1;

    logic                    chan_enable_reg, channel_select_reg;
    logic [22:0]             cycle_step_reg;
    logic [11:0]             frame_samples_reg;
    logic [15:0]             period_reg;
    logic signed [PA_W-1:0]  phase_acc_reg;
    logic signed [16:0]      env_acc_reg, sweep_acc_reg;
    logic [3:0]              env_level_reg, duty_step_reg, vol_setting_reg, duty_thr_reg;
    logic [7:0]              length_count_reg;
    logic [15:0]             env_delay_reg, sweep_delay_reg;
    logic                    constant_vol_reg, length_halt_reg;
    logic [2:0]              sweep_amount_reg;
    logic                    sweep_negate_reg, sweep_enable_reg;
    logic [11:0]             period_limit_reg;
    logic                    out_valid_reg;
    logic [12:0]             sample_reg, result_reg;

    logic signed [TOT_W-1:0] total_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [REM_W-1:0]        rem_reg, dvsr_reg;
    logic [QW-1:0]           quo_reg;
    logic                    neg_reg;

    logic [16:0]             env_prod, sweep_prod, per_p1;
    logic [15:0]             sweep_dly, sweep_sh, period_next;
    logic signed [PA_W-1:0]  step_val, cyc_val;
    logic [11:0]             amp;
    logic signed [TOT_W-1:0] amp_ext, total_abs;
    logic [3:0]              duty_next;

    assign env_prod   = {5'b0, frame_samples_reg} * {13'b0, 4'(in_data[3:0]) + 4'd0} +
                        {5'b0, frame_samples_reg};
    assign sweep_prod = {5'b0, frame_samples_reg} * {14'b0, in_data[6:4]} +
                        {5'b0, frame_samples_reg};
    assign per_p1     = {1'b0, period_reg} + 17'd1;
    assign step_val   = $signed({1'b0, per_p1, {PHASE_FRAC_BITS{1'b0}}});
    assign cyc_val    = $signed({{(PA_W-23){1'b0}}, cycle_step_reg});
    assign amp        = constant_vol_reg ? {vol_setting_reg, 8'b0} : {~env_level_reg, 8'b0};
    assign amp_ext    = $signed({{(TOT_W-12){1'b0}}, amp});
    assign total_abs  = total_reg[TOT_W-1] ? -total_reg : total_reg;
    assign duty_next  = duty_step_reg + 4'd1;
    assign sweep_dly  = (sweep_delay_reg == 16'd0) ? 16'd1 : sweep_delay_reg;
    assign sweep_sh   = period_reg >> sweep_amount_reg;

    always_comb
    begin
        if (!sweep_negate_reg)
        begin
            period_next = period_reg + sweep_sh;
        end
        else if (!channel_select_reg)
        begin
            period_next = period_reg - sweep_sh - 16'd1;
        end
        else
        begin
            period_next = period_reg - sweep_sh;
        end
    end

    assign sts.gated        = !chan_enable_reg || (length_count_reg == 8'd0) ||
                              (env_delay_reg == 16'd0);
    assign sts.env_neg      = env_acc_reg[16];
    assign sts.muted        = (period_reg < 16'd8) ||
                              (!sweep_negate_reg && (period_reg > {4'b0, period_limit_reg}));
    assign sts.sweep_active = sweep_enable_reg && (sweep_amount_reg != 3'd0);
    assign sts.sweep_neg    = sweep_acc_reg[16];
    assign sts.acc_neg      = phase_acc_reg[PA_W-1];
    assign sts.out_free     = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_sample = sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_enable_reg    <= 1'b0;
            channel_select_reg <= 1'b0;
            cycle_step_reg     <= pcsr_pkg::CYCLE_STEP_RST;
            frame_samples_reg  <= pcsr_pkg::FRAME_SAMPLES_RST;
            period_reg         <= '0;
            phase_acc_reg      <= '0;
            env_acc_reg        <= '0;
            sweep_acc_reg      <= '0;
            env_level_reg      <= '0;
            duty_step_reg      <= '0;
            length_count_reg   <= '0;
            vol_setting_reg    <= '0;
            env_delay_reg      <= '0;
            constant_vol_reg   <= 1'b0;
            length_halt_reg    <= 1'b0;
            duty_thr_reg       <= pcsr_pkg::DUTY_THR_RST;
            sweep_amount_reg   <= '0;
            sweep_negate_reg   <= 1'b0;
            sweep_enable_reg   <= 1'b0;
            sweep_delay_reg    <= pcsr_pkg::SWEEP_DELAY_RST;
            period_limit_reg   <= pcsr_pkg::PERIOD_LIMIT_RST;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    pcsr_pkg::CFG_ENABLE: chan_enable_reg    <= cfg_data[0];
                    pcsr_pkg::CFG_SELECT: channel_select_reg <= cfg_data[0];
                    pcsr_pkg::CFG_STEP:   cycle_step_reg     <= cfg_data;
                    pcsr_pkg::CFG_FRAME:  frame_samples_reg  <= cfg_data[11:0];
                    default:              chan_enable_reg    <= chan_enable_reg;
                endcase
            end
            if (cmd.wr)
            begin
                case (in_kind)
                    pcsr_pkg::KIND_REG0:
                    begin
                        vol_setting_reg  <= in_data[3:0];
                        env_delay_reg    <= env_prod[15:0];
                        constant_vol_reg <= in_data[4];
                        length_halt_reg  <= in_data[5];
                        duty_thr_reg     <= pcsr_pkg::DUTY_TABLE[in_data[7:6]];
                    end
                    pcsr_pkg::KIND_REG1:
                    begin
                        sweep_amount_reg <= in_data[2:0];
                        period_limit_reg <= pcsr_pkg::LIMIT_TABLE[in_data[2:0]];
                        sweep_negate_reg <= in_data[3];
                        sweep_delay_reg  <= sweep_prod[15:0];
                        sweep_enable_reg <= in_data[7];
                    end
                    pcsr_pkg::KIND_REG2:
                    begin
                        period_reg[7:0] <= in_data;
                    end
                    pcsr_pkg::KIND_REG3:
                    begin
                        period_reg       <= {5'b0, in_data[2:0], period_reg[7:0]};
                        length_count_reg <= pcsr_pkg::LEN_TABLE[in_data[7:3]];
                        env_level_reg    <= '0;
                        duty_step_reg    <= '0;
                    end
                    default:
                    begin
                        period_reg <= period_reg;
                    end
                endcase
            end
            if (cmd.tick_start)
            begin
                if (!length_halt_reg)
                begin
                    length_count_reg <= length_count_reg - 8'd1;
                end
                env_acc_reg <= env_acc_reg - 17'sd4;
            end
            if (cmd.env_step)
            begin
                env_acc_reg <= env_acc_reg + $signed({1'b0, env_delay_reg});
                if (length_halt_reg || (env_level_reg != 4'hF))
                begin
                    env_level_reg <= env_level_reg + 4'd1;
                end
            end
            if (cmd.sweep_start)
            begin
                sweep_acc_reg <= sweep_acc_reg - 17'sd2;
            end
            if (cmd.sweep_step)
            begin
                sweep_acc_reg <= sweep_acc_reg + $signed({1'b0, sweep_dly});
                period_reg    <= period_next;
            end
            if (cmd.phase_sub)
            begin
                phase_acc_reg <= phase_acc_reg - cyc_val;
            end
            if (cmd.acc_step)
            begin
                phase_acc_reg <= phase_acc_reg + step_val;
                duty_step_reg <= duty_next;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Work registers for the crossing average: loaded before use, no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.phase_sub)
        begin
            total_reg <= '0;
            count_reg <= '0;
        end
        if (cmd.acc_step)
        begin
            total_reg <= (duty_next < duty_thr_reg) ? total_reg + amp_ext : total_reg - amp_ext;
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.div_init)
        begin
            rem_reg  <= total_abs[REM_W-1:0];
            dvsr_reg <= {1'b0, count_reg, {(QW-1){1'b0}}};
            quo_reg  <= '0;
            neg_reg  <= total_reg[TOT_W-1];
        end
        if (cmd.div_step)
        begin
            if (rem_reg >= dvsr_reg)
            begin
                rem_reg <= rem_reg - dvsr_reg;
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
            dvsr_reg <= dvsr_reg >> 1;
        end
        if (cmd.res_zero)
        begin
            result_reg <= '0;
        end
        if (cmd.res_div)
        begin
            result_reg <= neg_reg ? -{1'b0, quo_reg} : {1'b0, quo_reg};
        end
        if (cmd.out_load)
        begin
            sample_reg <= result_reg;
        end
    end

endmodule

// ===== bench/pulse_channel_sample_render_top_tb.sv =====
// ---------------------------------------------------------------------------
// pulse_channel_sample_render_top_tb
// Self-checking bench for the pulse channel sample renderer: drives register
// writes and sample ticks with random gaps and output stalls, predicts each
// sample from its own channel model and compares every word on the output.
// ---------------------------------------------------------------------------
module pulse_channel_sample_render_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS   = pcsr_pkg::PHASE_FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int SETTLE      = 60;

    // Channel predictor plus the queue of samples still owed by the block.
    class render_scoreboard;
        logic        en, sel;
        logic [22:0] step_cfg;
        logic [11:0] frame_cfg;
        logic [15:0] period, env_dly, sweep_dly;
        longint      phase_acc;
        int          env_ctr, sweep_ctr;
        logic [3:0]  env_level, duty_pos, vol, duty_thr;
        logic [7:0]  len_cnt;
        logic        const_vol, halt, sw_neg, sw_en;
        logic [2:0]  sw_amt;
        logic [11:0] per_limit;
        logic [12:0] owed_samples[$];
        int          mismatches;

        function new();
            en = 1'b0; sel = 1'b0;
            step_cfg = pcsr_pkg::CYCLE_STEP_RST; frame_cfg = pcsr_pkg::FRAME_SAMPLES_RST;
            period = '0; phase_acc = 0; env_ctr = 0; sweep_ctr = 0;
            env_level = '0; duty_pos = '0; len_cnt = '0; vol = '0; env_dly = '0;
            const_vol = 1'b0; halt = 1'b0; duty_thr = pcsr_pkg::DUTY_THR_RST;
            sw_amt = '0; sw_neg = 1'b0; sw_en = 1'b0;
            sweep_dly = pcsr_pkg::SWEEP_DELAY_RST; per_limit = pcsr_pkg::PERIOD_LIMIT_RST;
            mismatches = 0;
        endfunction

        function void set_cfg(logic [1:0] addr, logic [22:0] val);
            case (addr)
                pcsr_pkg::CFG_ENABLE: en = val[0];
                pcsr_pkg::CFG_SELECT: sel = val[0];
                pcsr_pkg::CFG_STEP:   step_cfg = val;
                default:              frame_cfg = val[11:0];
            endcase
        endfunction

        function int render_tick();
            logic [15:0] sh;
            int          dly, amp;
            longint      stride, total, crossings;
            if (!en || len_cnt == 0 || env_dly == 0)
                return 0;
            if (!halt)
                len_cnt = len_cnt - 8'd1;
            // envelope runs before the mute check, so it advances even when muted
            env_ctr -= 4;
            while (env_ctr < 0)
            begin
                env_ctr += int'(env_dly);
                if (halt)
                    env_level = env_level + 4'd1;
                else if (env_level != 4'hF)
                    env_level = env_level + 4'd1;
            end
            if (period < 8 || (!sw_neg && period > {4'd0, per_limit}))
                return 0;
            if (sw_en && sw_amt != 0)
            begin
                dly = (sweep_dly != 0) ? int'(sweep_dly) : 1;
                sweep_ctr -= 2;
                while (sweep_ctr < 0)
                begin
                    sh = period >> sw_amt;
                    sweep_ctr += dly;
                    if (sw_neg)
                        period = sel ? period - sh : period - sh - 16'd1;
                    else
                        period = period + sh;
                end
            end
            phase_acc -= longint'(step_cfg);
            if (phase_acc >= 0)
                return 0;
            amp = const_vol ? int'(vol) << 8 : int'(env_level ^ 4'hF) << 8;
            stride = (longint'(period) + 1) <<< FRAC_BITS;
            total = 0;
            crossings = 0;
            while (phase_acc < 0)
            begin
                phase_acc += stride;
                duty_pos = duty_pos + 4'd1;
                total += (duty_pos < duty_thr) ? amp : -amp;
                crossings++;
            end
            return int'(total / crossings);
        endfunction

        function void note_word(logic [2:0] kind, logic [7:0] d);
            int s;
            case (kind)
                pcsr_pkg::KIND_REG0:
                begin
                    vol = d[3:0];
                    env_dly = frame_cfg * (vol + 16'd1);
                    const_vol = d[4];
                    halt = d[5];
                    duty_thr = pcsr_pkg::DUTY_TABLE[d[7:6]];
                end
                pcsr_pkg::KIND_REG1:
                begin
                    sw_amt = d[2:0];
                    per_limit = pcsr_pkg::LIMIT_TABLE[d[2:0]];
                    sw_neg = d[3];
                    sweep_dly = frame_cfg * ({13'd0, d[6:4]} + 16'd1);
                    sw_en = d[7];
                end
                pcsr_pkg::KIND_REG2: period[7:0] = d;
                pcsr_pkg::KIND_REG3:
                begin
                    period[15:8] = {5'd0, d[2:0]};
                    len_cnt = pcsr_pkg::LEN_TABLE[d[7:3]];
                    env_level = '0;
                    duty_pos = '0;
                end
                pcsr_pkg::KIND_TICK:
                begin
                    s = render_tick();
                    owed_samples.push_back(s[12:0]);
                end
                default: ;
            endcase
        endfunction

        function void check_sample(logic [12:0] got);
            logic [12:0] want;
            if (owed_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample %0d", $signed(got));
                return;
            end
            want = owed_samples.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("sample mismatch: expected %0d, got %0d",
                             $signed(want), $signed(got));
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_addr = '0;
    logic [22:0] cfg_data = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] write_data
    logic [2:0]  s_tuser = '0;   // [2:0] kind
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;        // [12:0] sample

    render_scoreboard sb = new();
    int  cycles = 0;
    int  hold_left = 0;   // receiver hold-off, counted down by the receiver
    bit  steady = 0;      // when set, neither side idles

    pulse_channel_sample_render_top uut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Watchdog: end the run with a failure once the cycle limit is passed.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: check each accepted sample, then pick next cycle's ready.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_sample(m_tdata[12:0]);
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (steady)
            m_tready <= 1'b1;
        else
        begin
            if ($urandom_range(0, 199) == 0)
                hold_left = $urandom_range(20, 120);
            m_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    // Offer one word, hold it until taken, then maybe idle a while.
    task automatic push_word(logic [2:0] kind, logic [7:0] d);
        int gap, roll;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= d;
        do @(posedge clk); while (!s_tready);
        sb.note_word(kind, d);
        roll = $urandom_range(0, 99);
        gap = steady ? 0 : (roll < 60) ? 0 : (roll < 92) ? $urandom_range(1, 3)
                                                      : $urandom_range(10, 40);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid, wait out every owed sample, and let the block go idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.owed_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write all four config registers back to back while idle.
    task automatic set_channel(logic en, logic sel, logic [22:0] stp, logic [11:0] frm);
        logic [22:0] vals[4];
        vals = '{{22'd0, en}, {22'd0, sel}, stp, {11'd0, frm}};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_addr <= i[1:0];
            cfg_data <= vals[i];
            @(posedge clk);
            sb.set_cfg(i[1:0], vals[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly full note setups followed by ticks; the rest is loose noise.
    task automatic random_words(int n);
        int sent;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                if ($urandom_range(0, 2) != 0)
                    push_word(pcsr_pkg::KIND_REG0, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) != 0)
                    push_word(pcsr_pkg::KIND_REG1, 8'($urandom_range(0, 255)));
                push_word(pcsr_pkg::KIND_REG2, 8'($urandom_range(0, 255)));
                push_word(pcsr_pkg::KIND_REG3, 8'($urandom_range(0, 255)));
                sent += 4;
                for (int t = $urandom_range(1, 12); t > 0; t--)
                begin
                    push_word(pcsr_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
                    sent++;
                end
            end
            else
            begin
                for (int t = $urandom_range(1, 4); t > 0; t--)
                begin
                    push_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Channel disabled and never set up: every tick is gated to zero.
        push_word(pcsr_pkg::KIND_TICK, 8'h00);
        push_word(3'd5, 8'hFF);
        push_word(3'd6, 8'h00);
        push_word(3'd7, 8'hFF);
        push_word(pcsr_pkg::KIND_REG0, 8'hFF);
        push_word(pcsr_pkg::KIND_REG3, 8'h08);
        push_word(pcsr_pkg::KIND_TICK, 8'hFF);
        drain();

        set_channel(1'b1, 1'b0, pcsr_pkg::CYCLE_STEP_RST, pcsr_pkg::FRAME_SAMPLES_RST);
        // Constant volume and halted length; period zero is muted.
        push_word(pcsr_pkg::KIND_REG0, 8'h3F);
        push_word(pcsr_pkg::KIND_REG2, 8'h00);
        push_word(pcsr_pkg::KIND_REG3, 8'h00);
        push_word(pcsr_pkg::KIND_TICK, 8'h00);
        // Period 0x010 with the longest length: audible.
        push_word(pcsr_pkg::KIND_REG2, 8'h10);
        push_word(pcsr_pkg::KIND_REG3, 8'h08);
        push_word(pcsr_pkg::KIND_TICK, 8'h00);
        push_word(pcsr_pkg::KIND_TICK, 8'h00);
        // Negative sweep at the largest shift.
        push_word(pcsr_pkg::KIND_REG1, 8'hFF);
        push_word(pcsr_pkg::KIND_TICK, 8'h00);
        // Top period over the sweep limit, no negate: muted.
        push_word(pcsr_pkg::KIND_REG1, 8'h07);
        push_word(pcsr_pkg::KIND_REG2, 8'hFF);
        push_word(pcsr_pkg::KIND_REG3, 8'h07);
        push_word(pcsr_pkg::KIND_TICK, 8'h00);
        // Decaying envelope with a two-tick length: runs out and gates.
        push_word(pcsr_pkg::KIND_REG0, 8'h80);
        push_word(pcsr_pkg::KIND_REG1, 8'h00);
        push_word(pcsr_pkg::KIND_REG2, 8'h40);
        push_word(pcsr_pkg::KIND_REG3, 8'h18);
        repeat (4) push_word(pcsr_pkg::KIND_TICK, 8'h00);

        // Long receiver hold-off while ticks keep coming: the block backs up.
        push_word(pcsr_pkg::KIND_REG0, 8'hBF);
        push_word(pcsr_pkg::KIND_REG2, 8'h20);
        push_word(pcsr_pkg::KIND_REG3, 8'h08);
        hold_left = 3000;
        repeat (30) push_word(pcsr_pkg::KIND_TICK, 8'h00);
        random_words(230);
        drain();

        steady = 1;
        set_channel(1'b1, 1'b1, 23'd4718591, 12'd1);
        random_words(260);
        drain();

        steady = 0;
        set_channel(1'b1, 1'b0, 23'd1, 12'd4095);
        random_words(150);
        drain();

        set_channel(1'b1, 1'b1, 23'($urandom_range(1, 4718591)), 12'($urandom_range(1, 4095)));
        random_words(300);
        drain();

        set_channel(1'b1, 1'b0, 23'($urandom_range(200000, 3000000)),
                    12'($urandom_range(1, 800)));
        random_words(300);
        drain();

        set_channel(1'b0, 1'b1, pcsr_pkg::CYCLE_STEP_RST, pcsr_pkg::FRAME_SAMPLES_RST);
        random_words(40);
        drain();

        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/pcsr_pkg.sv
src/pcsr_ctrl.sv
src/pcsr_dp.sv
src/pulse_channel_sample_render_top.sv
bench/pulse_channel_sample_render_top_tb.sv
